// File: rtl/pcc_pkg.sv
// Shared types, codes and helpers for the polygon convexity checker.
// Used by the top level and the turn pipeline; depends on nothing else.
`default_nettype none

package pcc_pkg;

  // Direction of one axis of an edge
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_e;

  // Configuration register indexes (one bit of paddr selects)
  localparam logic REG_EDGE_TOL = 1'b0;
  localparam logic REG_TURN_TOL = 1'b1;

  localparam int unsigned EDGE_TOL_W = 20;
  localparam int unsigned TURN_TOL_W = 48;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 4;

  // Flip counter saturation and the count a convex outline shows per axis
  localparam logic [1:0] FLIP_SAT    = 2'd3;
  localparam logic [1:0] FLIP_CONVEX = 2'd2;
  localparam logic [1:0] SEEN_SAT    = 2'd3;

  // Per-axis direction tracking state
  typedef struct packed {
    dir_e       dir;
    dir_e       first;
    logic [1:0] flips;
  } axis_t;

  // Control travelling alongside the edges into the turn pipeline
  typedef struct packed {
    logic t1_en;     // turn between previous edge and this edge
    logic close_en;  // closing turns on the final vertex
    logic fin;       // final vertex, a result beat follows
    logic too_few;   // fewer than three vertices
    logic axes_ok;   // both axes show exactly two flips
  } pcc_ctl_t;

  typedef struct packed {
    logic too_few;
    logic is_convex;
  } pcc_res_t;

  localparam axis_t AXIS_RESET = '{dir: DIR_NONE, first: DIR_NONE, flips: 2'd0};

  // Step one axis with the direction of a new edge
  function automatic axis_t axis_step(axis_t a, dir_e nd);
    axis_t r;
    r = a;
    if (nd != DIR_NONE) begin
      if (a.dir == DIR_NONE) begin
        r.first = nd;
      end else if (a.dir != nd && a.flips != FLIP_SAT) begin
        r.flips = a.flips + 2'd1;
      end
      r.dir = nd;
    end
    return r;
  endfunction

  // Flip between the last and the first significant direction
  function automatic axis_t axis_wrap(axis_t a);
    axis_t r;
    r = a;
    if (a.dir != DIR_NONE && a.first != DIR_NONE && a.dir != a.first &&
        a.flips != FLIP_SAT) begin
      r.flips = a.flips + 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pcc_turn.sv
// Cross-product pipeline: products stage, compare stage, turn flag tracking.
// Depends on pcc_pkg for the control and result structs.
`default_nettype none

module pcc_turn #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [pcc_pkg::TURN_TOL_W-1:0]        turn_tol_i,
  // edges: prev x/y, this x/y, closing x/y, first x/y
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [COORD_BITS:0]            edges_i [8],
  input  wire pcc_pkg::pcc_ctl_t                     ctl_i,
  input  wire logic                                  res_free_i,
  output logic                                       res_valid_o,
  output pcc_pkg::pcc_res_t                          res_o
);

  localparam int unsigned EW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned CW = (PW + 1 > pcc_pkg::TURN_TOL_W + 1) ?
                               PW + 1 : pcc_pkg::TURN_TOL_W + 1;

  // Stage 1: edges held for the multipliers
  logic                 s1_v_q, s1_v_d;
  logic signed [EW-1:0] edg_q [8];
  pcc_pkg::pcc_ctl_t    s1_ctl_q;

  // Stage 2: products held for the subtract and compare
  logic                 s2_v_q, s2_v_d;
  logic signed [PW-1:0] prod_q [6];
  logic signed [PW-1:0] prod_d [6];
  pcc_pkg::pcc_ctl_t    s2_ctl_q;

  // Turn flags of the polygon in progress
  logic left_q, left_d, right_q, right_d;

  logic s1_go, s1_free, s2_go, s2_free, push;

  // handshake between stages
  always_comb begin
    s2_go       = s2_v_q && (!s2_ctl_q.fin || res_free_i);
    s2_free     = !s2_v_q || s2_go;
    s1_go       = s1_v_q && s2_free;
    s1_free     = !s1_v_q || s1_go;
    in_ready_o  = s1_free;
    push        = in_valid_i && s1_free;
    res_valid_o = s2_v_q && s2_ctl_q.fin && res_free_i;
    s1_v_d      = push ? 1'b1 : (s1_go ? 1'b0 : s1_v_q);
    s2_v_d      = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_v_q);
  end

  // products: prev x this, this x closing, closing x first
  always_comb begin
    prod_d[0] = PW'(edg_q[0]) * PW'(edg_q[3]);
    prod_d[1] = PW'(edg_q[1]) * PW'(edg_q[2]);
    prod_d[2] = PW'(edg_q[2]) * PW'(edg_q[5]);
    prod_d[3] = PW'(edg_q[3]) * PW'(edg_q[4]);
    prod_d[4] = PW'(edg_q[4]) * PW'(edg_q[7]);
    prod_d[5] = PW'(edg_q[5]) * PW'(edg_q[6]);
  end

  logic signed [CW-1:0] tol_s;
  logic signed [CW-1:0] wx [3];
  logic [2:0]           en, gt, lt;
  logic                 left_any, right_any;

  // cross products against the turn tolerance
  always_comb begin
    tol_s = $signed(CW'(turn_tol_i));
    en    = {s2_ctl_q.close_en, s2_ctl_q.close_en, s2_ctl_q.t1_en};
    for (int k = 0; k < 3; k++) begin
      wx[k] = CW'(prod_q[2*k]) - CW'(prod_q[2*k+1]);
      gt[k] = en[k] && (wx[k] > tol_s);
      lt[k] = en[k] && (wx[k] < -tol_s);
    end
    left_any  = left_q  || (|gt);
    right_any = right_q || (|lt);
    res_o.too_few   = s2_ctl_q.too_few;
    res_o.is_convex = s2_ctl_q.axes_ok && !(left_any && right_any);
    left_d  = left_q;
    right_d = right_q;
    if (s2_go) begin
      left_d  = s2_ctl_q.fin ? 1'b0 : left_any;
      right_d = s2_ctl_q.fin ? 1'b0 : right_any;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      left_q  <= 1'b0;
      right_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (push) begin
      edg_q    <= edges_i;
      s1_ctl_q <= ctl_i;
    end
    if (s1_go) begin
      prod_q   <= prod_d;
      s2_ctl_q <= s1_ctl_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/polygon_convexity_check_top.sv
// Convexity check: one vertex per cycle unless a stalled result holds the
// input, direction flips counted on entry, turns found by a two-stage
// cross-product pipeline (pcc_turn). Uses pcc_pkg. A final vertex's result
// beat passes the edge, products and output registers; the products stage
// sets the clock.
// Reset (async, low): polygon state, pipeline and output emptied,
// both tolerances cleared to zero.
`default_nettype none

module polygon_convexity_check_top #(
  parameter int unsigned COORD_BITS = 24,
  localparam int unsigned IN_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [pcc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [pcc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pcc_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                    pready,
  // vertex beats
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [IN_W-1:0]                    s_axis_tdata,  // vertex_x, vertex_y, zero pad
  input  wire logic                               s_axis_tlast,  // final_vertex
  // result beats
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [7:0]                              m_axis_tdata   // is_convex, too_few_vertices, pad
);

  localparam int unsigned EW = COORD_BITS + 1;
  localparam int unsigned DW = ((EW > pcc_pkg::EDGE_TOL_W) ? EW : pcc_pkg::EDGE_TOL_W) + 1;

  // Configuration registers
  logic [pcc_pkg::EDGE_TOL_W-1:0] edge_tol_q;
  logic [pcc_pkg::TURN_TOL_W-1:0] turn_tol_q;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_tol_q <= '0;
      turn_tol_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        pcc_pkg::REG_EDGE_TOL: edge_tol_q <= pwdata[pcc_pkg::EDGE_TOL_W-1:0];
        pcc_pkg::REG_TURN_TOL: turn_tol_q <= pwdata[pcc_pkg::TURN_TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (paddr[3])
      pcc_pkg::REG_EDGE_TOL: prdata = pcc_pkg::APB_DATA_W'(edge_tol_q);
      pcc_pkg::REG_TURN_TOL: prdata = pcc_pkg::APB_DATA_W'(turn_tol_q);
      default:               prdata = '0;
    endcase
  end

  // Direction of one edge component against the edge tolerance
  function automatic pcc_pkg::dir_e classify(logic signed [EW-1:0] d,
                                             logic [pcc_pkg::EDGE_TOL_W-1:0] tol);
    logic signed [DW-1:0] dw;
    logic signed [DW-1:0] tw;
    dw = DW'(d);
    tw = $signed(DW'(tol));
    if (dw > tw)       return pcc_pkg::DIR_POS;
    else if (dw < -tw) return pcc_pkg::DIR_NEG;
    else               return pcc_pkg::DIR_NONE;
  endfunction

  // Polygon state
  logic signed [COORD_BITS-1:0] first_x_q, first_y_q, second_x_q, second_y_q;
  logic signed [COORD_BITS-1:0] older_x_q, older_y_q, latest_x_q, latest_y_q;
  logic [1:0]                   seen_q, seen_d;
  pcc_pkg::axis_t               ax_x_q, ax_x_d, ax_y_q, ax_y_d;

  logic signed [COORD_BITS-1:0] vx, vy;
  logic signed [EW-1:0]         edges [8];
  pcc_pkg::axis_t               x_e, y_e, x_w, y_w;
  pcc_pkg::pcc_ctl_t            ctl;
  logic                         in_ready, accept;

  assign vx            = s_axis_tdata[COORD_BITS-1:0];
  assign vy            = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign s_axis_tready = in_ready;
  assign accept        = s_axis_tvalid && in_ready;

  // edges and direction tracking for the incoming vertex
  always_comb begin
    edges[0] = EW'(latest_x_q) - EW'(older_x_q);
    edges[1] = EW'(latest_y_q) - EW'(older_y_q);
    edges[2] = EW'(vx) - EW'(latest_x_q);
    edges[3] = EW'(vy) - EW'(latest_y_q);
    edges[4] = EW'(first_x_q) - EW'(vx);
    edges[5] = EW'(first_y_q) - EW'(vy);
    edges[6] = EW'(second_x_q) - EW'(first_x_q);
    edges[7] = EW'(second_y_q) - EW'(first_y_q);

    // the very first vertex has no edge yet
    x_e = ax_x_q;
    y_e = ax_y_q;
    if (seen_q != 2'd0) begin
      x_e = pcc_pkg::axis_step(ax_x_q, classify(edges[2], edge_tol_q));
      y_e = pcc_pkg::axis_step(ax_y_q, classify(edges[3], edge_tol_q));
    end
    // closing edge, then wrap flip
    x_w = pcc_pkg::axis_wrap(pcc_pkg::axis_step(x_e, classify(edges[4], edge_tol_q)));
    y_w = pcc_pkg::axis_wrap(pcc_pkg::axis_step(y_e, classify(edges[5], edge_tol_q)));

    ctl.t1_en    = seen_q[1];
    ctl.close_en = s_axis_tlast && seen_q[1];
    ctl.fin      = s_axis_tlast;
    ctl.too_few  = s_axis_tlast && !seen_q[1];
    ctl.axes_ok  = seen_q[1] && (x_w.flips == pcc_pkg::FLIP_CONVEX) &&
                   (y_w.flips == pcc_pkg::FLIP_CONVEX);

    seen_d = seen_q;
    ax_x_d = ax_x_q;
    ax_y_d = ax_y_q;
    if (accept) begin
      if (s_axis_tlast) begin
        seen_d = 2'd0;
        ax_x_d = pcc_pkg::AXIS_RESET;
        ax_y_d = pcc_pkg::AXIS_RESET;
      end else begin
        seen_d = (seen_q == pcc_pkg::SEEN_SAT) ? seen_q : seen_q + 2'd1;
        ax_x_d = x_e;
        ax_y_d = y_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
      ax_x_q <= pcc_pkg::AXIS_RESET;
      ax_y_q <= pcc_pkg::AXIS_RESET;
    end else begin
      seen_q <= seen_d;
      ax_x_q <= ax_x_d;
      ax_y_q <= ax_y_d;
    end
  end

  // vertex history
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (seen_q == 2'd0) begin
        first_x_q <= vx;
        first_y_q <= vy;
      end
      if (seen_q == 2'd1) begin
        second_x_q <= vx;
        second_y_q <= vy;
      end
      older_x_q  <= latest_x_q;
      older_y_q  <= latest_y_q;
      latest_x_q <= vx;
      latest_y_q <= vy;
    end
  end

  // Turn pipeline
  logic              res_free, res_valid;
  pcc_pkg::pcc_res_t res;

  pcc_turn #(
    .COORD_BITS (COORD_BITS)
  ) u_turn (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .turn_tol_i  (turn_tol_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (in_ready),
    .edges_i     (edges),
    .ctl_i       (ctl),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register
  logic              m_valid_q, m_valid_d;
  pcc_pkg::pcc_res_t m_res_q;

  assign res_free      = !m_valid_q || m_axis_tready;
  assign m_valid_d     = res_valid ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_res_q.too_few, m_res_q.is_convex};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_res_q <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pcc_checker.sv
// Port-level checks for the convexity checker, bound to the top level.
// Sees only the top level's ports; no package needed.
`default_nettype none

module pcc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  // no result beat while reset is held
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result beat during reset");

  // a stalled result beat holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // too few vertices is never reported convex
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("convex flagged with too few vertices");

  // input backpressure only when the output is full and stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a stalled result");

endmodule

bind polygon_convexity_check_top pcc_checker u_pcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: bench/tb_polygon_convexity_check_top.sv
// Self-checking bench for polygon_convexity_check_top: scripted and random outlines in,
// verdict beats checked against a built-in convexity predictor.
// Depends on rtl/pcc_pkg.sv and rtl/polygon_convexity_check_top.sv, which uses rtl/pcc_turn.sv.
`default_nettype none

module tb_polygon_convexity_check_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  localparam int          COORD_W         = 24;
  localparam int          IN_W            = ((2 * COORD_W + 7) / 8) * 8;
  localparam longint      COORD_MAX       = 64'sd8388607;
  localparam longint      COORD_MIN       = -64'sd8388608;
  localparam longint      EDGE_TOL_MAX    = (64'sd1 <<< EDGE_TOL_W) - 1;
  localparam longint      TURN_TOL_MAX    = (64'sd1 <<< TURN_TOL_W) - 1;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          STOP_CYCLES     = 400000;
  localparam int          NUM_ROWS        = 25;
  localparam int          NUM_PHASES      = 6;
  localparam int          ITEMS_PER_PHASE = 220;
  localparam int          MAX_SIDES       = 12;
  localparam real         PI              = 3.141592653589793;

  // Register byte addresses (8-byte stride, the turn tolerance is wider than 32 bits)
  localparam logic [APB_ADDR_W-1:0] EDGE_TOL_ADDR = {REG_EDGE_TOL, 3'b000};
  localparam logic [APB_ADDR_W-1:0] TURN_TOL_ADDR = {REG_TURN_TOL, 3'b000};

  // Outline shapes for the random part
  localparam int SHAPE_CONVEX = 0;
  localparam int SHAPE_REPEAT = 1;
  localparam int SHAPE_DENT   = 2;
  localparam int SHAPE_NOISE  = 3;
  localparam int SHAPE_FEW    = 4;

  // Receiver stall patterns
  localparam int RX_OPEN      = 0;
  localparam int RX_RANDOM    = 1;
  localparam int RX_LONG_STALL = 2;
  localparam int RX_ALTERNATE = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    int     x;
    int     y;
    logic   last;
    logic   typed;
    logic   convex;
    logic   few;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid, s_tready, s_tlast;
  logic [IN_W-1:0]       s_tdata;
  logic                  m_tvalid, m_tready;
  logic [7:0]            m_tdata;

  // Predictor copies of the registers and of the outline state
  longint     tol_edge, tol_turn;
  longint     first_x, first_y, second_x, second_y;
  longint     older_x, older_y, latest_x, latest_y;
  int         seen;
  dir_e       heading [2];
  dir_e       opening [2];
  logic [1:0] flips [2];
  bit         turned_left, turned_right;

  pcc_res_t    verdict_q [$];
  longint      xs [$];
  longint      ys [$];
  script_row_t script [NUM_ROWS];
  int          n_errors;
  int          burst_left;
  int unsigned cycle_count;
  int unsigned rx_cycle, rx_hold;
  bit          rx_ready;

  polygon_convexity_check_top #(.COORD_BITS(COORD_W)) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // vertex_x, vertex_y
    .s_axis_tlast  (s_tlast),   // final_vertex
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)    // is_convex, too_few_vertices, pad
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- predictor
  function void clear_outline();
    first_x = 0; first_y = 0; second_x = 0; second_y = 0;
    older_x = 0; older_y = 0; latest_x = 0; latest_y = 0;
    seen = 0;
    for (int a = 0; a < 2; a++) begin
      heading[a] = DIR_NONE;
      opening[a] = DIR_NONE;
      flips[a]   = 2'd0;
    end
    turned_left  = 1'b0;
    turned_right = 1'b0;
  endfunction

  function void track_axis(input int a, input longint d);
    dir_e nd;
    if (d > tol_edge) begin
      nd = DIR_POS;
    end else if (d < -tol_edge) begin
      nd = DIR_NEG;
    end else begin
      return;
    end
    if (heading[a] == DIR_NONE) begin
      opening[a] = nd;
    end else if (heading[a] != nd && flips[a] != FLIP_SAT) begin
      flips[a] = flips[a] + 2'd1;
    end
    heading[a] = nd;
  endfunction

  function void track_turn(input longint ax, input longint ay, input longint bx,
                           input longint by);
    longint w;
    w = ax * by - ay * bx;
    if (w > tol_turn) turned_left = 1'b1;
    if (w < -tol_turn) turned_right = 1'b1;
  endfunction

  // Direction change between the last and the first significant direction
  function void close_axis(input int a);
    if (heading[a] != DIR_NONE && opening[a] != DIR_NONE && heading[a] != opening[a] &&
        flips[a] != FLIP_SAT) begin
      flips[a] = flips[a] + 2'd1;
    end
  endfunction

  function void predict_verdict(input longint vx, input longint vy, input bit last,
                                output bit has_res, output pcc_res_t res);
    longint ex, ey, cx, cy;
    ex = vx - latest_x;
    ey = vy - latest_y;
    res = '0;
    if (seen == 0) begin
      first_x = vx;
      first_y = vy;
    end else begin
      track_axis(0, ex);
      track_axis(1, ey);
      if (seen >= 2) begin
        track_turn(latest_x - older_x, latest_y - older_y, ex, ey);
      end else begin
        second_x = vx;
        second_y = vy;
      end
    end
    if (seen < int'(SEEN_SAT)) seen++;
    older_x  = latest_x;
    older_y  = latest_y;
    latest_x = vx;
    latest_y = vy;
    has_res  = last;
    if (!last) return;
    if (seen < 3) begin
      res.too_few = 1'b1;
    end else begin
      cx = first_x - vx;
      cy = first_y - vy;
      track_axis(0, cx);
      track_axis(1, cy);
      track_turn(ex, ey, cx, cy);
      track_turn(cx, cy, second_x - first_x, second_y - first_y);
      close_axis(0);
      close_axis(1);
      res.is_convex = flips[0] == FLIP_CONVEX && flips[1] == FLIP_CONVEX &&
                      !(turned_left && turned_right);
    end
    clear_outline();
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // bus left idle before the next transfer
    @(negedge clk);
  endtask

  // Write both tolerances and read them back
  task automatic set_tolerances(input longint e_tol, input longint t_tol);
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b1, EDGE_TOL_ADDR, APB_DATA_W'(e_tol), rd);
    apb_access(1'b1, TURN_TOL_ADDR, APB_DATA_W'(t_tol), rd);
    tol_edge = e_tol;
    tol_turn = t_tol;
    apb_access(1'b0, EDGE_TOL_ADDR, '0, rd);
    if (rd[EDGE_TOL_W-1:0] != e_tol[EDGE_TOL_W-1:0]) begin
      $display("%0t: edge tolerance readback expected %0d actual %0d", $time, e_tol,
               rd[EDGE_TOL_W-1:0]);
      n_errors++;
    end
    apb_access(1'b0, TURN_TOL_ADDR, '0, rd);
    if (rd[TURN_TOL_W-1:0] != t_tol[TURN_TOL_W-1:0]) begin
      $display("%0t: turn tolerance readback expected %0d actual %0d", $time, t_tol,
               rd[TURN_TOL_W-1:0]);
      n_errors++;
    end
  endtask

  // One vertex beat; the sender runs in bursts with random gaps between them
  task automatic send_vertex(input longint vx, input longint vy, input bit last,
                             input bit typed, input pcc_res_t typed_res);
    int       gap;
    coord_t   cx, cy;
    bit       has_res;
    pcc_res_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
    end
    cx = vx[COORD_W-1:0];
    cy = vy[COORD_W-1:0];
    s_tvalid <= 1'b1;
    s_tdata  <= {cy, cx};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_verdict(longint'(cx), longint'(cy), last, has_res, res);
    if (has_res) verdict_q.insert(verdict_q.size(), typed ? typed_res : res);
    burst_left--;
    @(negedge clk);
  endtask

  // Let the block drain before touching the registers or ending
  task automatic settle();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic build_outline(input int shape);
    int     n, k;
    real    r, ang, wsum;
    real    w [MAX_SIDES];
    longint cx, cy, lim, px, py;
    bit     reverse;
    xs.delete();
    ys.delete();
    if (shape == SHAPE_FEW || shape == SHAPE_NOISE) begin
      n = (shape == SHAPE_FEW) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      for (int i = 0; i < n; i++) begin
        xs.insert(xs.size(), longint'($urandom_range(0, 24'hFFFFFF)) + COORD_MIN);
        ys.insert(ys.size(), longint'($urandom_range(0, 24'hFFFFFF)) + COORD_MIN);
      end
    end else begin
      // Points in angular order on a circle: convex before rounding
      n = $urandom_range(3, MAX_SIDES);
      k = $urandom_range(0, n - 1);
      r = ($urandom_range(0, 2) == 0) ? real'($urandom_range(1, 300)) :
                                        real'($urandom_range(100000, 8300000));
      lim = COORD_MAX - longint'($rtoi(r)) - 1;
      cx = longint'($urandom_range(0, int'(2 * lim))) - lim;
      cy = longint'($urandom_range(0, int'(2 * lim))) - lim;
      wsum = 0.0;
      for (int i = 0; i < n; i++) begin
        w[i] = real'($urandom_range(1, 100));
        wsum += w[i];
      end
      ang = real'($urandom_range(0, 359)) * PI / 180.0;
      reverse = ($urandom_range(0, 1) == 1);
      for (int i = 0; i < n; i++) begin
        px = cx + longint'($rtoi(r * $cos(ang)));
        py = cy + longint'($rtoi(r * $sin(ang)));
        if (shape == SHAPE_DENT && i == k) begin
          px = cx + (px - cx) / 4;
          py = cy + (py - cy) / 4;
        end
        xs.insert(xs.size(), px);
        ys.insert(ys.size(), py);
        if (shape == SHAPE_REPEAT && i == k) begin
          xs.insert(xs.size(), px);
          ys.insert(ys.size(), py);
        end
        ang += (reverse ? -2.0 : 2.0) * PI * w[i] / wsum;
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver
  always @(negedge clk) begin
    case (int'(rx_cycle[8:7]))
      RX_OPEN: rx_ready = 1'b1;
      RX_RANDOM: rx_ready = ($urandom_range(0, 3) != 0);
      RX_LONG_STALL: begin
        if (rx_hold != 0) begin
          rx_ready = 1'b0;
          rx_hold--;
        end else begin
          rx_ready = 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 12);
        end
      end
      RX_ALTERNATE: rx_ready = rx_cycle[0];
      default: rx_ready = 1'b1;
    endcase
    m_tready <= rx_ready;
    rx_cycle++;
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual is_convex %0b too_few %0b", $time,
                 m_tdata[0], m_tdata[1]);
        n_errors++;
      end else begin
        if (m_tdata[0] != verdict_q[0].is_convex) begin
          $display("%0t: is_convex expected %0b actual %0b", $time, verdict_q[0].is_convex,
                   m_tdata[0]);
          n_errors++;
        end
        if (m_tdata[1] != verdict_q[0].too_few) begin
          $display("%0t: too_few_vertices expected %0b actual %0b", $time,
                   verdict_q[0].too_few, m_tdata[1]);
          n_errors++;
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > STOP_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
    m_tready = 1'b0;
    n_errors = 0; burst_left = 0; cycle_count = 0; rx_cycle = 0; rx_hold = 0;
    tol_edge = 0; tol_turn = 0;
    clear_outline();

    // x, y, final, typed, convex, too few
    script = '{
      // single vertex at the coordinate extremes
      '{-8388608,  8388607, 1'b1, 1'b1, 1'b0, 1'b1},
      // two vertices
      '{ 8388607,  8388607, 1'b0, 1'b0, 1'b0, 1'b0},
      '{-8388608, -8388608, 1'b1, 1'b1, 1'b0, 1'b1},
      // square of side 100, anticlockwise
      '{       0,        0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{     100,        0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{     100,      100, 1'b0, 1'b0, 1'b0, 1'b0},
      '{       0,      100, 1'b1, 1'b1, 1'b1, 1'b0},
      // triangle spanning the full range
      '{-8388608, -8388608, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ 8388607, -8388608, 1'b0, 1'b0, 1'b0, 1'b0},
      '{       0,  8388607, 1'b1, 1'b0, 1'b0, 1'b0},
      // self-crossing bow tie: mixed turns
      '{       0,        0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{     100,      100, 1'b0, 1'b0, 1'b0, 1'b0},
      '{     100,        0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{       0,      100, 1'b1, 1'b0, 1'b0, 1'b0},
      // repeated vertex gives a degenerate edge
      '{       0,        0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{       0,        0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{      50,        0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{      50,       50, 1'b1, 1'b0, 1'b0, 1'b0},
      // collinear points: no significant turn at all
      '{       0,        0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{      10,        0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{      20,        0, 1'b1, 1'b0, 1'b0, 1'b0},
      // clockwise square on the corners of the range
      '{ 8388607,  8388607, 1'b0, 1'b0, 1'b0, 1'b0},
      '{ 8388607, -8388608, 1'b0, 1'b0, 1'b0, 1'b0},
      '{-8388608, -8388608, 1'b0, 1'b0, 1'b0, 1'b0},
      '{-8388608,  8388607, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Scripted outlines at reset tolerances
    set_tolerances(0, 0);
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_vertex(longint'(script[i].x), longint'(script[i].y), script[i].last,
                  script[i].typed, '{too_few: script[i].few, is_convex: script[i].convex});
    end

    // Random outlines, one tolerance setting per phase
    for (int p = 1; p <= NUM_PHASES; p++) begin
      int placed;
      int pick;
      settle();
      case (p)
        1: set_tolerances(0, 0);
        2: set_tolerances(EDGE_TOL_MAX, TURN_TOL_MAX);
        3: set_tolerances(longint'($urandom_range(0, 31)), longint'($urandom_range(0, 4095)));
        4: set_tolerances(longint'($urandom_range(0, int'(EDGE_TOL_MAX))),
                          longint'({16'($urandom), 32'($urandom)}));
        5: set_tolerances(0, TURN_TOL_MAX);
        default: set_tolerances(EDGE_TOL_MAX, 0);
      endcase
      placed = 0;
      while (placed < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) build_outline(SHAPE_CONVEX);
        else if (pick == 6) build_outline(SHAPE_REPEAT);
        else if (pick == 7) build_outline(SHAPE_DENT);
        else if (pick == 8) build_outline(SHAPE_NOISE);
        else build_outline(SHAPE_FEW);
        for (int i = 0; i < xs.size(); i++) begin
          send_vertex(xs[i], ys[i], i == xs.size() - 1, 1'b0, '0);
        end
        placed += xs.size();
      end
    end

    settle();
    if (verdict_q.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: polygon_convexity_check_top.f
rtl/pcc_pkg.sv
rtl/pcc_turn.sv
rtl/polygon_convexity_check_top.sv
rtl/pcc_checker.sv
bench/tb_polygon_convexity_check_top.sv
